[design/sacl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int ADDR_W      = 64;
	localparam int NUM_SETS    = 256;
	localparam int SET_W       = $clog2(NUM_SETS);
	localparam int NUM_WAYS    = 8;
	localparam int WAY_W       = $clog2(NUM_WAYS);
	localparam int CNT_W       = 32;

	localparam int SET_BITS_W   = 4;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_USED_W  = 4;
	localparam int CFG_DATA_W   = 6;
	localparam int CFG_INDEX_W  = 2;
	localparam int SHIFT_W      = 7;

	localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
	localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
	localparam logic [WAYS_USED_W-1:0]  WAYS_USED_RST  = 4'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_BITS = 2 + 1 + 1 + 3 * CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS_USED  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_IFETCH = 2'd3
	} cmd_t;

	typedef enum logic {
		BK_READ   = 1'b0,
		BK_UPDATE = 1'b1
	} back_state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SET_W-1:0]  idx;
		logic [ADDR_W-1:0] tag;
	} access_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] tag;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

[design/set_assoc_lru_cache_tags.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Each input beat carries a command (tuser) and a byte address (tdata) and
// yields one result beat with this item's hits, miss and eviction flags and
// the saturating running totals. The back end handles each item in a read
// state, which reads the set's row from the single-port set memory, and an
// update state, which searches, reorders and writes the row back. A modify
// needs no extra state, and an instruction fetch passes through both states
// without writing the memory. A two-entry queue lets the input take beats
// while the back end works or a result waits. Lines reset to invalid at once
// through one valid bit per set; no clearing pass is run. Configuration must
// be written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sacl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [sacl_pkg::ADDR_W-1:0]         s_tdata,   // address
	input  wire logic [1:0]                          s_tuser,   // cmd
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// hits[1:0], missed, evicted, hit_total[31:0], miss_total[31:0],
	// eviction_total[31:0], zero fill
	output logic [sacl_pkg::OUT_W-1:0]               m_tdata
);

	logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_q;
	logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_q;
	logic [sacl_pkg::WAYS_USED_W-1:0]  ways_used_q;

	logic                     push;
	logic                     pop;
	sacl_pkg::access_t        push_item;
	sacl_pkg::access_t        head;
	sacl_pkg::queue_status_t  q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= sacl_pkg::SET_BITS_RST;
			block_bits_q <= sacl_pkg::BLOCK_BITS_RST;
			ways_used_q  <= sacl_pkg::WAYS_USED_RST;
		end else if (cfg_we) begin
			case (sacl_pkg::cfg_reg_t'(cfg_index))
				sacl_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_wdata[sacl_pkg::SET_BITS_W-1:0];
				sacl_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				sacl_pkg::CFG_WAYS_USED:  ways_used_q  <= cfg_wdata[sacl_pkg::WAYS_USED_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	sacl_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.set_bits   (set_bits_q),
		.block_bits (block_bits_q),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	sacl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	sacl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ways_used (ways_used_q),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

[design/sacl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_front
// Input side: splits each address into set index and tag and pushes the
// access into the queue.
// ----------------------------------------------------------------------------
module sacl_front (
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [sacl_pkg::ADDR_W-1:0]         s_tdata,   // address
	input  wire logic [1:0]                          s_tuser,   // cmd
	input  wire logic [sacl_pkg::SET_BITS_W-1:0]     set_bits,
	input  wire logic [sacl_pkg::BLOCK_BITS_W-1:0]   block_bits,
	input  wire sacl_pkg::queue_status_t             q_status,
	output logic                                     push,
	output sacl_pkg::access_t                        push_item
);

	logic [sacl_pkg::ADDR_W-1:0]  block_addr;
	logic [sacl_pkg::SET_W-1:0]   set_mask;
	logic [sacl_pkg::SHIFT_W-1:0] tag_shift;

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		block_addr = s_tdata >> block_bits;
		for (int i = 0; i < sacl_pkg::SET_W; i++) begin
			set_mask[i] = (set_bits > sacl_pkg::SET_BITS_W'(i));
		end
		tag_shift = sacl_pkg::SHIFT_W'(set_bits) + sacl_pkg::SHIFT_W'(block_bits);

		push_item.cmd = sacl_pkg::cmd_t'(s_tuser);
		push_item.idx = block_addr[sacl_pkg::SET_W-1:0] & set_mask;
		if (tag_shift >= sacl_pkg::SHIFT_W'(sacl_pkg::ADDR_W)) begin
			push_item.tag = '0;
		end else begin
			push_item.tag = s_tdata >> tag_shift;
		end
	end

endmodule
`default_nettype wire

[design/sacl_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_queue
// Short FIFO of classified accesses between front and back.
// ----------------------------------------------------------------------------
module sacl_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire sacl_pkg::access_t       push_item,
	input  wire logic                    pop,
	output sacl_pkg::access_t            head,
	output sacl_pkg::queue_status_t      status
);

	sacl_pkg::access_t                 entry_q [sacl_pkg::QUEUE_DEPTH];
	logic [sacl_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sacl_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sacl_pkg::QCNT_W-1:0]       count_q;

	function automatic logic [sacl_pkg::QPTR_W-1:0] next_ptr(
		input logic [sacl_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == sacl_pkg::QPTR_W'(sacl_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == sacl_pkg::QCNT_W'(sacl_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/sacl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_back
// Executes accesses: reads a set row, searches and reorders it in LRU order,
// writes it back, updates the totals and holds the result beat.
// ----------------------------------------------------------------------------
module sacl_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [sacl_pkg::WAYS_USED_W-1:0]    ways_used,
	input  wire sacl_pkg::access_t                   head,
	input  wire sacl_pkg::queue_status_t             q_status,
	output logic                                     pop,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [sacl_pkg::OUT_W-1:0]               m_tdata
);

	sacl_pkg::back_state_t state_q, state_d;
	logic                  update;

	// set rows, one row per set, each row all ways
	sacl_pkg::row_t                 mem [sacl_pkg::NUM_SETS];
	logic [sacl_pkg::NUM_SETS-1:0]  row_valid_q;
	sacl_pkg::row_t                 rd_row_s2;
	logic                           rd_row_valid_s2;
	sacl_pkg::access_t              item_s2;

	sacl_pkg::row_t                 old_row;
	sacl_pkg::row_t                 new_row;
	logic [sacl_pkg::WAYS_USED_W-1:0] ways_eff;
	logic [sacl_pkg::WAY_W-1:0]     last_way;
	logic [sacl_pkg::WAY_W-1:0]     hit_way;
	logic [sacl_pkg::WAY_W-1:0]     move_pos;
	logic                           found;
	logic                           is_access;
	logic                           first_hit;
	logic                           miss;
	logic                           evict;
	logic [1:0]                     hit_inc;

	logic [sacl_pkg::CNT_W-1:0]     hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [sacl_pkg::CNT_W-1:0]     hit_cnt_d, miss_cnt_d, evict_cnt_d;
	logic [sacl_pkg::CNT_W:0]       hit_sum, miss_sum, evict_sum;

	logic                           m_tvalid_q;
	logic [1:0]                     hits_q;
	logic                           missed_q;
	logic                           evicted_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sacl_pkg::BK_READ: begin
				if (pop) begin
					state_d = sacl_pkg::BK_UPDATE;
				end
			end
			sacl_pkg::BK_UPDATE: state_d = sacl_pkg::BK_READ;
			default:             state_d = sacl_pkg::BK_READ;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop    = 1'b0;
		update = 1'b0;
		case (state_q)
			sacl_pkg::BK_READ:   pop = !q_status.empty && (!m_tvalid_q || m_tready);
			sacl_pkg::BK_UPDATE: update = 1'b1;
			default: begin
				pop    = 1'b0;
				update = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (ways_used == '0) begin
			ways_eff = sacl_pkg::WAYS_USED_W'(1);
		end else if (ways_used > sacl_pkg::WAYS_USED_W'(sacl_pkg::NUM_WAYS)) begin
			ways_eff = sacl_pkg::WAYS_USED_W'(sacl_pkg::NUM_WAYS);
		end else begin
			ways_eff = ways_used;
		end
		last_way = sacl_pkg::WAY_W'(ways_eff - 1'b1);

		// a row never written reads as all lines invalid
		old_row = rd_row_valid_s2 ? rd_row_s2 : '0;

		found   = 1'b0;
		hit_way = '0;
		for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
			if (!found && (sacl_pkg::WAYS_USED_W'(w) < ways_eff) && old_row[w].valid
			    && (old_row[w].tag == item_s2.tag)) begin
				found   = 1'b1;
				hit_way = sacl_pkg::WAY_W'(w);
			end
		end

		// shift lines back up to the hit way, or the last way in use on a miss
		move_pos = found ? hit_way : last_way;
		new_row[0].valid = 1'b1;
		new_row[0].tag   = item_s2.tag;
		for (int k = 1; k < sacl_pkg::NUM_WAYS; k++) begin
			if (sacl_pkg::WAY_W'(k) <= move_pos) begin
				new_row[k] = old_row[k-1];
			end else begin
				new_row[k] = old_row[k];
			end
		end

		is_access = (item_s2.cmd != sacl_pkg::CMD_IFETCH);
		first_hit = is_access && found;
		miss      = is_access && !found;
		evict     = miss && old_row[last_way].valid;
		// the second access of a modify always hits the line just placed in front
		hit_inc   = {1'b0, first_hit} + {1'b0, (item_s2.cmd == sacl_pkg::CMD_MODIFY)};

		hit_sum   = {1'b0, hit_cnt_q} + (sacl_pkg::CNT_W + 1)'(hit_inc);
		miss_sum  = {1'b0, miss_cnt_q} + (sacl_pkg::CNT_W + 1)'(miss);
		evict_sum = {1'b0, evict_cnt_q} + (sacl_pkg::CNT_W + 1)'(evict);
		hit_cnt_d   = hit_sum[sacl_pkg::CNT_W]   ? '1 : hit_sum[sacl_pkg::CNT_W-1:0];
		miss_cnt_d  = miss_sum[sacl_pkg::CNT_W]  ? '1 : miss_sum[sacl_pkg::CNT_W-1:0];
		evict_cnt_d = evict_sum[sacl_pkg::CNT_W] ? '1 : evict_sum[sacl_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (update && is_access) begin
			mem[item_s2.idx] <= new_row;
		end
		if (pop) begin
			rd_row_s2       <= mem[head.idx];
			rd_row_valid_s2 <= row_valid_q[head.idx];
			item_s2         <= head;
		end
		if (update) begin
			hits_q    <= hit_inc;
			missed_q  <= miss;
			evicted_q <= evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacl_pkg::BK_READ;
			row_valid_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (update) begin
				if (is_access) begin
					row_valid_q[item_s2.idx] <= 1'b1;
				end
				hit_cnt_q   <= hit_cnt_d;
				miss_cnt_q  <= miss_cnt_d;
				evict_cnt_q <= evict_cnt_d;
				m_tvalid_q  <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {
		(sacl_pkg::OUT_W - sacl_pkg::OUT_BITS)'(0),
		evict_cnt_q, miss_cnt_q, hit_cnt_q, evicted_q, missed_q, hits_q
	};

endmodule
`default_nettype wire

[bench/set_assoc_lru_cache_tags_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_check
// Watches the configuration port and both streams of the LRU tag store, keeps
// its own copy of the tag rows and totals, and compares every result beat
// against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [sacl_pkg::ADDR_W-1:0]      s_tdata,   // address
	input  logic [1:0]                       s_tuser,   // cmd
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// hits[1:0], missed, evicted, hit_total[31:0], miss_total[31:0],
	// eviction_total[31:0], zero fill
	input  logic [sacl_pkg::OUT_W-1:0]       m_tdata,
	output int                               pending,
	output int                               fail_count
);
	import sacl_pkg::*;

	typedef struct packed {
		logic [1:0]       hits;
		logic             missed;
		logic             evicted;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} outcome_t;

	outcome_t          outcome_q[$];
	logic              way_valid [NUM_SETS][NUM_WAYS];
	logic [ADDR_W-1:0] way_tag   [NUM_SETS][NUM_WAYS];
	logic [CNT_W-1:0]  hit_cnt, miss_cnt, evict_cnt;
	logic [3:0]        set_bits;
	logic [5:0]        block_bits;
	logic [3:0]        ways_used;
	int                beat_no;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// One lookup in the recency list; returns 1 on a hit.
	function automatic bit touch(input logic [ADDR_W-1:0] addr, output bit evict);
		int                shift;
		int                ways;
		int                hit_at;
		bit                hit;
		logic [ADDR_W-1:0] set_sel;
		logic [ADDR_W-1:0] tag;
		logic [SET_W-1:0]  row;
		shift   = int'(set_bits) + int'(block_bits);
		set_sel = (addr >> block_bits) & ((64'd1 << set_bits) - 64'd1);
		tag     = (shift >= ADDR_W) ? '0 : (addr >> shift);
		ways    = (ways_used == 0) ? 1 : (ways_used > NUM_WAYS) ? NUM_WAYS : int'(ways_used);
		row     = set_sel[SET_W-1:0];
		evict   = 1'b0;
		hit_at  = ways;
		for (int w = ways - 1; w >= 0; w--)
			if (way_valid[row][w] && way_tag[row][w] == tag)
				hit_at = w;
		hit = (hit_at != ways);
		if (hit) begin
			hit_cnt = bump(hit_cnt);
		end else begin
			miss_cnt = bump(miss_cnt);
			if (way_valid[row][ways-1]) begin
				evict     = 1'b1;
				evict_cnt = bump(evict_cnt);
			end
			hit_at = ways - 1;
		end
		// age everything in front of the touched way, then move it to the front
		for (int k = hit_at; k > 0; k--) begin
			way_valid[row][k] = way_valid[row][k-1];
			way_tag[row][k]   = way_tag[row][k-1];
		end
		way_valid[row][0] = 1'b1;
		way_tag[row][0]   = tag;
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		bit       ev_first;
		bit       ev_second;
		if (!arst_n) begin
			outcome_q.delete();
			for (int s = 0; s < NUM_SETS; s++)
				for (int w = 0; w < NUM_WAYS; w++) begin
					way_valid[s][w] = 1'b0;
					way_tag[s][w]   = '0;
				end
			hit_cnt    = '0;
			miss_cnt   = '0;
			evict_cnt  = '0;
			set_bits   = SET_BITS_RST;
			block_bits = BLOCK_BITS_RST;
			ways_used  = WAYS_USED_RST;
			beat_no    = 0;
			pending    = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SET_BITS:   set_bits   = cfg_wdata[3:0];
					CFG_BLOCK_BITS: block_bits = cfg_wdata[5:0];
					CFG_WAYS_USED:  ways_used  = cfg_wdata[3:0];
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.hits           = m_tdata[1:0];
				got.missed         = m_tdata[2];
				got.evicted        = m_tdata[3];
				got.hit_total      = m_tdata[35:4];
				got.miss_total     = m_tdata[67:36];
				got.eviction_total = m_tdata[99:68];
				if (outcome_q.size() == 0) begin
					if (fail_count < 10)
						$display("result beat %0d arrived with nothing expected", beat_no);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.hits !== want.hits || got.missed !== want.missed ||
					    got.evicted !== want.evicted || got.hit_total !== want.hit_total ||
					    got.miss_total !== want.miss_total ||
					    got.eviction_total !== want.eviction_total) begin
						if (fail_count < 10)
							$display({"result beat %0d: expected hits=%0d missed=%0d ",
								"evicted=%0d totals=%0d/%0d/%0d, got hits=%0d missed=%0d ",
								"evicted=%0d totals=%0d/%0d/%0d"}, beat_no,
								want.hits, want.missed, want.evicted, want.hit_total,
								want.miss_total, want.eviction_total,
								got.hits, got.missed, got.evicted, got.hit_total,
								got.miss_total, got.eviction_total);
						fail_count++;
					end
				end
				beat_no++;
			end

			if (s_tvalid && s_tready) begin
				want = '0;
				if (cmd_t'(s_tuser) != CMD_IFETCH) begin
					if (touch(s_tdata, ev_first))
						want.hits = 2'd1;
					else
						want.missed = 1'b1;
					want.evicted = ev_first;
					// modify: second access to the same line
					if (cmd_t'(s_tuser) == CMD_MODIFY && touch(s_tdata, ev_second))
						want.hits = want.hits + 2'd1;
				end
				want.hit_total      = hit_cnt;
				want.miss_total     = miss_cnt;
				want.eviction_total = evict_cnt;
				outcome_q.push_back(want);
			end

			pending = outcome_q.size();
		end
	end

endmodule

[bench/set_assoc_lru_cache_tags_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_test
// Drives the LRU tag store with directed accesses and then random traffic
// over a series of cache geometries, with random stalls on both streams;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_test;
	import sacl_pkg::*;

	localparam int ITEMS_PER_PHASE = 138;
	localparam int NUM_GEOS        = 11;
	localparam int RECENT          = 16;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [ADDR_W-1:0]      s_tdata;
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_W-1:0]       m_tdata;
	int                     pending;
	int                     fail_count;

	logic                   quiet = 1'b0;
	int                     stall_left = 0;
	int                     cur_sb = 4;
	int                     cur_bb = 4;
	int                     cur_wu = 1;
	logic [ADDR_W-1:0]      recent [RECENT];
	int                     recent_wr = 0;

	// raw register values; some exceed the field ranges on purpose
	int geo_sb [NUM_GEOS] = '{0, 8, 63, 3, 8, 2, 5, 1, 12, 0, 8};
	int geo_bb [NUM_GEOS] = '{0, 32, 63, 6, 0, 12, 5, 40, 3, 0, 4};
	int geo_wu [NUM_GEOS] = '{1, 8, 63, 4, 0, 8, 3, 2, 9, 1, 8};

	set_assoc_lru_cache_tags dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	set_assoc_lru_cache_tags_check checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #5 clk = ~clk;

	// result side: random stall bursts, none started in quiet phases
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input cmd_t c, input logic [ADDR_W-1:0] a);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		s_tuser  <= c;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the input until every result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_geometry(input int sb, input int bb, input int wu);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SET_BITS;
		cfg_wdata <= sb[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_BLOCK_BITS;
		cfg_wdata <= bb[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_WAYS_USED;
		cfg_wdata <= wu[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_sb = sb & 15;
		cur_bb = bb & 63;
		cur_wu = wu & 15;
	endtask

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 19);
		if (r < 6)
			return CMD_LOAD;
		else if (r < 11)
			return CMD_STORE;
		else if (r < 17)
			return CMD_MODIFY;
		return CMD_IFETCH;
	endfunction

	// Mostly reuse recent lines or pick few tags in few sets, so hits and
	// evictions both happen; the rest is fully random addresses.
	function automatic logic [ADDR_W-1:0] next_address();
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] off_mask;
		int                r;
		int                ways;
		off_mask = (64'd1 << cur_bb) - 64'd1;
		ways = (cur_wu == 0) ? 1 : (cur_wu > NUM_WAYS) ? NUM_WAYS : cur_wu;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			a = {$urandom, $urandom};
		end else if (r < 60) begin
			a = recent[$urandom_range(0, RECENT - 1)] ^ ({$urandom, $urandom} & off_mask);
		end else begin
			a = {$urandom, $urandom} & off_mask;
			a |= (64'($urandom_range(0, 3)) & ((64'd1 << cur_sb) - 64'd1)) << cur_bb;
			if (cur_sb + cur_bb < ADDR_W)
				a |= 64'($urandom_range(0, ways + 2)) << (cur_sb + cur_bb);
		end
		recent[recent_wr] = a;
		recent_wr = (recent_wr + 1) % RECENT;
		return a;
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SET_BITS;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_LOAD;
		for (int i = 0; i < RECENT; i++)
			recent[i] = '0;
		geo_sb[9] = $urandom_range(0, 8);
		geo_bb[9] = $urandom_range(0, 20);
		geo_wu[9] = $urandom_range(1, 8);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: 16 sets, 16-byte lines, direct mapped
		send_item(CMD_IFETCH, 64'h0);
		send_item(CMD_LOAD,   64'h0);
		send_item(CMD_LOAD,   64'h8);
		send_item(CMD_STORE,  64'h0);
		send_item(CMD_MODIFY, 64'h100);
		send_item(CMD_MODIFY, 64'h100);
		send_item(CMD_LOAD,   64'h0);
		send_item(CMD_STORE,  64'h10);
		send_item(CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(CMD_LOAD,   64'h8000_0000_0000_0000);
		send_item(CMD_STORE,  64'h5555_5555_5555_5555);
		send_item(CMD_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);
		send_item(CMD_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(CMD_LOAD,   64'h5555_5555_5555_5555);
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			send_item(pick_cmd(), next_address());

		// stored lines survive each geometry change
		for (int p = 0; p < NUM_GEOS; p++) begin
			drain();
			quiet = (p == 3 || p == NUM_GEOS - 1);
			program_geometry(geo_sb[p], geo_bb[p], geo_wu[p]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 1 && i == ITEMS_PER_PHASE / 2)
					drain();
				send_item(pick_cmd(), next_address());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
